FILE: hw/rtl/pso_vpu_pkg.sv
// Shared types, register indexes and reset values for the PSO update core.
package pso_vpu_pkg;

	localparam int unsigned CFG_ADDR_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_UPDATE_MODE    = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_INERTIA_WEIGHT = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_COGNITIVE_GAIN = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SOCIAL_GAIN    = 2'd3;

	localparam logic        MODE_INERTIA_ONLY = 1'b0;
	localparam logic        MODE_SCALE_ALL    = 1'b1;
	localparam logic [15:0] RST_INERTIA       = 16'd2867;
	localparam logic [15:0] RST_COGNITIVE     = 16'd8192;
	localparam logic [15:0] RST_SOCIAL        = 16'd8192;

	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	// Per-item fields that ride along the pipe unchanged
	typedef struct packed {
		logic signed [31:0] position;
		logic signed [31:0] vel_min;
		logic signed [31:0] vel_max;
		logic signed [31:0] pos_min;
		logic signed [31:0] pos_max;
		logic               last;
	} side_t;

	// Load enables for the two register stages inside one unit
	typedef struct packed {
		logic en_a;
		logic en_b;
	} stage_ctl_t;

endpackage

FILE: hw/rtl/pso_velocity_position_update_core.sv
// Top level: PSO per-dimension velocity and position update, six-stage pipe.
//
//  channel  | dir | contents
//  s_axis   | in  | tdata: position, velocity, personal_best, leader_position,
//           |     |        rand_cognitive, rand_social, vel_min, vel_max,
//           |     |        pos_min, pos_max; tlast: last_dimension
//  m_axis   | out | tdata: new_velocity, new_position; tuser: reflected;
//           |     | tlast: last_of_particle
//  cfg      | in  | cfg_we / cfg_addr / cfg_wdata, write only
//
// One transaction per cycle sustained while m_axis_tready stays high; each
// accepted input moves through every stage register to the output register.
// The depth is set by three chained multiplies (gain x random, gain x
// distance, weight x sum in the scaled mode), each with its own register.
// Every stage has a valid bit; a stage loads when it is empty or its
// successor moves, so bubbles collapse while the output is held.
// Reset clears valid bits and loads the register defaults.
module pso_velocity_position_update_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [31:0] position, [63:32] velocity, [95:64] personal_best,
	// [127:96] leader_position, [143:128] rand_cognitive,
	// [159:144] rand_social, [191:160] vel_min, [223:192] vel_max,
	// [255:224] pos_min, [287:256] pos_max
	input  logic [287:0]                        s_axis_tdata,
	input  logic                                s_axis_tlast,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] new_velocity, [63:32] new_position
	output logic [63:0]                         m_axis_tdata,
	// [0] reflected
	output logic [0:0]                          m_axis_tuser,
	output logic                                m_axis_tlast,
	input  logic                                cfg_we,
	input  logic [pso_vpu_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [pso_vpu_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import pso_vpu_pkg::*;

	localparam int unsigned NSTAGE = 6;

	logic        mode_q;
	logic [15:0] weight_q, cog_q, soc_q;

	logic [NSTAGE:1] vld_q;
	logic [NSTAGE:1] en;

	side_t              side_in, side_s2, side_s4;
	logic signed [37:0] t1_s2, t2_s2;
	logic signed [36:0] wv_s2;
	logic signed [31:0] vel_s2;
	logic signed [44:0] sum_s4;
	logic signed [31:0] nv_s6, np_s6;
	logic               refl_s6, last_s6;
	stage_ctl_t         ctl_att, ctl_cmb, ctl_bnd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_INERTIA_ONLY;
			weight_q <= RST_INERTIA;
			cog_q    <= RST_COGNITIVE;
			soc_q    <= RST_SOCIAL;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_UPDATE_MODE:    mode_q   <= cfg_wdata[0];
				REG_INERTIA_WEIGHT: weight_q <= cfg_wdata;
				REG_COGNITIVE_GAIN: cog_q    <= cfg_wdata;
				REG_SOCIAL_GAIN:    soc_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// ready ripples back from the output register
	always_comb begin
		en[NSTAGE] = !vld_q[NSTAGE] || m_axis_tready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) vld_q[1] <= s_axis_tvalid;
			for (int k = 2; k <= NSTAGE; k++) begin
				if (en[k]) vld_q[k] <= vld_q[k-1];
			end
		end
	end

	assign s_axis_tready = en[1];

	assign side_in.position = s_axis_tdata[31:0];
	assign side_in.vel_min  = s_axis_tdata[191:160];
	assign side_in.vel_max  = s_axis_tdata[223:192];
	assign side_in.pos_min  = s_axis_tdata[255:224];
	assign side_in.pos_max  = s_axis_tdata[287:256];
	assign side_in.last     = s_axis_tlast;

	assign ctl_att = '{en_a: en[1], en_b: en[2]};
	assign ctl_cmb = '{en_a: en[3], en_b: en[4]};
	assign ctl_bnd = '{en_a: en[5], en_b: en[6]};

	pso_vpu_attract u_attract (
		.clk             (clk),
		.ctl             (ctl_att),
		.inertia_weight  (weight_q),
		.cognitive_gain  (cog_q),
		.social_gain     (soc_q),
		.velocity        (s_axis_tdata[63:32]),
		.personal_best   (s_axis_tdata[95:64]),
		.leader_position (s_axis_tdata[127:96]),
		.rand_cognitive  (s_axis_tdata[143:128]),
		.rand_social     (s_axis_tdata[159:144]),
		.side_in         (side_in),
		.t1_s2           (t1_s2),
		.t2_s2           (t2_s2),
		.wv_s2           (wv_s2),
		.vel_s2          (vel_s2),
		.side_s2         (side_s2)
	);

	pso_vpu_combine u_combine (
		.clk            (clk),
		.ctl            (ctl_cmb),
		.update_mode    (mode_q),
		.inertia_weight (weight_q),
		.t1             (t1_s2),
		.t2             (t2_s2),
		.wv             (wv_s2),
		.vel            (vel_s2),
		.side_in        (side_s2),
		.sum_s4         (sum_s4),
		.side_s4        (side_s4)
	);

	pso_vpu_bound u_bound (
		.clk             (clk),
		.ctl             (ctl_bnd),
		.sum             (sum_s4),
		.side_in         (side_s4),
		.new_velocity_s6 (nv_s6),
		.new_position_s6 (np_s6),
		.reflected_s6    (refl_s6),
		.last_s6         (last_s6)
	);

	assign m_axis_tvalid   = vld_q[NSTAGE];
	assign m_axis_tdata    = {np_s6, nv_s6};
	assign m_axis_tuser[0] = refl_s6;
	assign m_axis_tlast    = last_s6;

endmodule

FILE: hw/rtl/pso_vpu_attract.sv
// Stages 1-2: random gains, distances, inertia product and attraction terms.
module pso_vpu_attract (
	input  logic                      clk,
	input  pso_vpu_pkg::stage_ctl_t   ctl,
	input  logic [15:0]               inertia_weight,
	input  logic [15:0]               cognitive_gain,
	input  logic [15:0]               social_gain,
	input  logic signed [31:0]        velocity,
	input  logic signed [31:0]        personal_best,
	input  logic signed [31:0]        leader_position,
	input  logic [15:0]               rand_cognitive,
	input  logic [15:0]               rand_social,
	input  pso_vpu_pkg::side_t        side_in,
	output logic signed [37:0]        t1_s2,
	output logic signed [37:0]        t2_s2,
	output logic signed [36:0]        wv_s2,
	output logic signed [31:0]        vel_s2,
	output pso_vpu_pkg::side_t        side_s2
);
	import pso_vpu_pkg::*;

	logic [31:0]        gp1, gp2;
	logic signed [32:0] d1, d2;
	logic signed [48:0] wv_full;
	logic [15:0]        g1_s1, g2_s1;
	logic signed [32:0] d1_s1, d2_s1;
	logic signed [36:0] wv_s1;
	logic signed [31:0] vel_s1;
	side_t              side_s1;
	logic signed [49:0] t1_full, t2_full;

	assign gp1     = cognitive_gain * rand_cognitive;
	assign gp2     = social_gain * rand_social;
	assign d1      = {personal_best[31], personal_best} - {side_in.position[31], side_in.position};
	assign d2      = {leader_position[31], leader_position} - {side_in.position[31], side_in.position};
	assign wv_full = $signed({1'b0, inertia_weight}) * velocity;

	always_ff @(posedge clk) begin
		if (ctl.en_a) begin
			g1_s1   <= gp1[31:16];
			g2_s1   <= gp2[31:16];
			d1_s1   <= d1;
			d2_s1   <= d2;
			wv_s1   <= wv_full[48:12];
			vel_s1  <= velocity;
			side_s1 <= side_in;
		end
	end

	assign t1_full = $signed({1'b0, g1_s1}) * d1_s1;
	assign t2_full = $signed({1'b0, g2_s1}) * d2_s1;

	always_ff @(posedge clk) begin
		if (ctl.en_b) begin
			t1_s2   <= t1_full[49:12];
			t2_s2   <= t2_full[49:12];
			wv_s2   <= wv_s1;
			vel_s2  <= vel_s1;
			side_s2 <= side_s1;
		end
	end

endmodule

FILE: hw/rtl/pso_vpu_combine.sv
// Stages 3-4: sum of the velocity terms and the mode-dependent weighting.
module pso_vpu_combine (
	input  logic                      clk,
	input  pso_vpu_pkg::stage_ctl_t   ctl,
	input  logic                      update_mode,
	input  logic [15:0]               inertia_weight,
	input  logic signed [37:0]        t1,
	input  logic signed [37:0]        t2,
	input  logic signed [36:0]        wv,
	input  logic signed [31:0]        vel,
	input  pso_vpu_pkg::side_t        side_in,
	output logic signed [44:0]        sum_s4,
	output pso_vpu_pkg::side_t        side_s4
);
	import pso_vpu_pkg::*;

	logic signed [39:0] t1_x, t2_x, sum_inertia, sum_inner;
	logic signed [39:0] sel_s3;
	side_t              side_s3;
	logic signed [56:0] prod;

	assign t1_x        = {{2{t1[37]}}, t1};
	assign t2_x        = {{2{t2[37]}}, t2};
	assign sum_inertia = {{3{wv[36]}}, wv} + t1_x + t2_x;
	assign sum_inner   = {{8{vel[31]}}, vel} + t1_x + t2_x;

	always_ff @(posedge clk) begin
		if (ctl.en_a) begin
			sel_s3  <= (update_mode == MODE_SCALE_ALL) ? sum_inner : sum_inertia;
			side_s3 <= side_in;
		end
	end

	assign prod = $signed({1'b0, inertia_weight}) * sel_s3;

	always_ff @(posedge clk) begin
		if (ctl.en_b) begin
			if (update_mode == MODE_SCALE_ALL) begin
				sum_s4 <= prod[56:12];
			end else begin
				sum_s4 <= {{5{sel_s3[39]}}, sel_s3};
			end
			side_s4 <= side_s3;
		end
	end

endmodule

FILE: hw/rtl/pso_vpu_bound.sv
// Stages 5-6: saturation, velocity clamp, position step, reflection.
module pso_vpu_bound (
	input  logic                      clk,
	input  pso_vpu_pkg::stage_ctl_t   ctl,
	input  logic signed [44:0]        sum,
	input  pso_vpu_pkg::side_t        side_in,
	output logic signed [31:0]        new_velocity_s6,
	output logic signed [31:0]        new_position_s6,
	output logic                      reflected_s6,
	output logic                      last_s6
);
	import pso_vpu_pkg::*;

	logic signed [31:0] sat, lo_v, vel_c;
	logic signed [31:0] nv_s5;
	side_t              side_s5;
	logic signed [32:0] praw, pmin_x, pmax_x, p_lo;
	logic               refl;
	logic signed [31:0] nv_out, np_out;

	always_comb begin
		if (sum > $signed({{13{S32_MAX[31]}}, S32_MAX})) begin
			sat = S32_MAX;
		end else if (sum < $signed({{13{S32_MIN[31]}}, S32_MIN})) begin
			sat = S32_MIN;
		end else begin
			sat = sum[31:0];
		end
		lo_v  = (sat < side_in.vel_min) ? side_in.vel_min : sat;
		vel_c = (lo_v > side_in.vel_max) ? side_in.vel_max : lo_v;
	end

	always_ff @(posedge clk) begin
		if (ctl.en_a) begin
			nv_s5   <= vel_c;
			side_s5 <= side_in;
		end
	end

	always_comb begin
		praw   = {side_s5.position[31], side_s5.position} + {nv_s5[31], nv_s5};
		pmin_x = {side_s5.pos_min[31], side_s5.pos_min};
		pmax_x = {side_s5.pos_max[31], side_s5.pos_max};
		refl   = (praw < pmin_x) || (praw > pmax_x);
		if (!refl) begin
			nv_out = nv_s5;
		end else if (nv_s5 == S32_MIN) begin
			nv_out = S32_MAX;
		end else begin
			nv_out = -nv_s5;
		end
		// crossed bounds fall through to pos_max
		p_lo   = (praw < pmin_x) ? pmin_x : praw;
		np_out = (p_lo > pmax_x) ? side_s5.pos_max : p_lo[31:0];
	end

	always_ff @(posedge clk) begin
		if (ctl.en_b) begin
			new_velocity_s6 <= nv_out;
			new_position_s6 <= np_out;
			reflected_s6    <= refl;
			last_s6         <= side_s5.last;
		end
	end

endmodule

FILE: hw/rtl/pso_vpu_checker.sv
// Port-level checks for the PSO update core, bound onto the top level.
module pso_vpu_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [63:0]                         m_axis_tdata,
	input logic [0:0]                          m_axis_tuser,
	input logic                                m_axis_tlast
);

	// downstream ready lets every stage move, so the input side is open
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tready |-> s_axis_tready)
		else $error("input stalled while output side ready");

	a_ready_when_out_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// result reaches the output register after accept when the output side is never stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
		##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready
		|=> m_axis_tvalid)
		else $error("result missing after pipeline latency");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
		&& $stable(m_axis_tuser) && $stable(m_axis_tlast))
		else $error("stalled output transaction changed");

endmodule

bind pso_velocity_position_update_core pso_vpu_checker u_pso_vpu_checker (.*);
